/* hdl/small_square_matrix_multiply_defines.svh */
// assertion macros for the matrix multiplier
`ifndef SMALL_SQUARE_MATRIX_MULTIPLY_DEFINES_SVH
`define SMALL_SQUARE_MATRIX_MULTIPLY_DEFINES_SVH

`ifndef ASSERT_OFF
`define SSMM_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: check failed");
`define SSMM_ASSERT_NEVER(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("%m: forbidden condition seen");
`else
`define SSMM_ASSERT(label, prop)
`define SSMM_ASSERT_NEVER(label, cond)
`endif

`endif

/* hdl/ssmm_pkg.sv */
`timescale 1ns / 1ps

package ssmm_pkg;

    localparam int MAX_DIM    = 4;
    localparam int ELEM_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int DIM_W      = 3;

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int N_W    = $clog2(MAX_DIM + 1);
    localparam int IDX_W  = $clog2(MAX_DIM);
    localparam int PROD_W = 2 * ELEM_WIDTH;
    localparam int ACC_W  = PROD_W + $clog2(MAX_DIM) + 1;

    typedef logic signed [ELEM_WIDTH-1:0] elem_t;

    typedef struct packed {
        elem_t value;
        logic  sat;
    } lane_res_t;

    // travels down the multiply-accumulate pipeline next to the data
    typedef struct packed {
        logic           valid;
        logic           first;
        logic           last;
        logic           col_last;
        logic [N_W-1:0] n;
    } ctrl_t;

endpackage

/* hdl/ssmm_ram.sv */
`timescale 1ns / 1ps

module ssmm_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hdl/ssmm_lane.sv */
`timescale 1ns / 1ps

module ssmm_lane
    import ssmm_pkg::*;
(
    input  logic              clk,
    input  logic              a_we,
    input  logic [ADDR_W-1:0] a_waddr,
    input  elem_t             a_wdata,
    input  logic [ADDR_W-1:0] a_raddr,
    input  elem_t             b_rdata,
    input  logic              acc_en,
    input  logic              acc_clr,
    input  logic              hold,
    output lane_res_t         res
);

    localparam elem_t ELEM_MAX = {1'b0, {(ELEM_WIDTH-1){1'b1}}};
    localparam elem_t ELEM_MIN = {1'b1, {(ELEM_WIDTH-1){1'b0}}};

    logic [ELEM_WIDTH-1:0]     a_rdata;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [PROD_W-1:0]  prod_next;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [ACC_W-1:0]   acc_next;
    logic signed [ACC_W-1:0]   shifted;
    logic [ACC_W-ELEM_WIDTH:0] upper;
    logic                      fits;
    lane_res_t                 res_reg;
    lane_res_t                 res_next;

    // private copy of the left matrix, one read port per lane
    ssmm_ram #(
        .DEPTH (DEPTH),
        .WIDTH (ELEM_WIDTH)
    ) u_a_ram (
        .clk   (clk),
        .we    (a_we),
        .waddr (a_waddr),
        .wdata (a_wdata),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    always_comb
    begin
        prod_next = $signed(a_rdata) * b_rdata;
        acc_next  = (acc_clr ? '0 : acc_reg) + ACC_W'(prod_reg);
    end

    // drop fraction bits, then clip to element range
    always_comb
    begin
        shifted        = acc_reg >>> FRAC_BITS;
        upper          = shifted[ACC_W-1:ELEM_WIDTH-1];
        fits           = (&upper) || !(|upper);
        res_next.sat   = !fits;
        res_next.value = fits ? shifted[ELEM_WIDTH-1:0]
                              : (acc_reg[ACC_W-1] ? ELEM_MIN : ELEM_MAX);
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        if (acc_en)
        begin
            acc_reg <= acc_next;
        end
        if (hold)
        begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

/* hdl/ssmm_merge.sv */
`timescale 1ns / 1ps

`include "small_square_matrix_multiply_defines.svh"

module ssmm_merge
    import ssmm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      hold,
    input  ctrl_t     hold_ctrl,
    input  lane_res_t lane_res [MAX_DIM],
    input  logic      out_stall,
    output logic      out_valid,
    output elem_t     c_value,
    output logic      saturated,
    output logic      last,
    output logic      col_done
);

    logic             res_full_reg;
    logic             res_full_next;
    logic             res_last_reg;
    logic [N_W-1:0]   res_n_reg;
    lane_res_t        bank_reg [MAX_DIM];
    logic             bank_full_reg;
    logic             bank_full_next;
    logic             bank_last_reg;
    logic [N_W-1:0]   bank_n_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic             out_valid_reg;
    elem_t            out_value_reg;
    logic             out_sat_reg;
    logic             out_last_reg;

    logic             out_free;
    logic             emit;
    logic             emit_end;
    logic             load_bank;
    lane_res_t        pick;

    always_comb
    begin
        out_free  = !out_valid_reg || !out_stall;
        emit      = bank_full_reg && out_free;
        emit_end  = emit && (idx_reg == IDX_W'(bank_n_reg - N_W'(1)));
        load_bank = res_full_reg && (!bank_full_reg || emit_end);
        pick      = bank_reg[idx_reg];

        res_full_next = hold ? 1'b1 : (load_bank ? 1'b0 : res_full_reg);

        bank_full_next = bank_full_reg;
        idx_next       = idx_reg;
        if (emit)
        begin
            idx_next = idx_reg + IDX_W'(1);
        end
        if (emit_end)
        begin
            bank_full_next = 1'b0;
            idx_next       = '0;
        end
        if (load_bank)
        begin
            bank_full_next = 1'b1;
            idx_next       = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_full_reg  <= 1'b0;
            bank_full_reg <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            res_full_reg  <= res_full_next;
            bank_full_reg <= bank_full_next;
            idx_reg       <= idx_next;
            if (out_free)
            begin
                out_valid_reg <= emit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (hold)
        begin
            res_last_reg <= hold_ctrl.col_last;
            res_n_reg    <= hold_ctrl.n;
        end
        if (load_bank)
        begin
            bank_reg      <= lane_res;
            bank_last_reg <= res_last_reg;
            bank_n_reg    <= res_n_reg;
        end
        if (emit)
        begin
            out_value_reg <= pick.value;
            out_sat_reg   <= pick.sat;
            out_last_reg  <= bank_last_reg && emit_end;
        end
    end

    assign out_valid = out_valid_reg;
    assign c_value   = out_value_reg;
    assign saturated = out_sat_reg;
    assign last      = out_last_reg;
    assign col_done  = emit_end;

    `SSMM_ASSERT_NEVER(a_res_overrun, hold && res_full_reg && !load_bank)
    `SSMM_ASSERT_NEVER(a_idx_range, bank_full_reg && (N_W'(idx_reg) >= bank_n_reg))
    `SSMM_ASSERT(a_bank_drain, emit_end && !load_bank |=> !bank_full_reg)

endmodule

/* hdl/small_square_matrix_multiply.sv */
`timescale 1ns / 1ps

`include "small_square_matrix_multiply_defines.svh"

// Multiplies two square matrices of order n = 2, 3 or 4 (set by cfg_data,
// applied while idle; out-of-range values clamp). Each input request brings
// one element of A and of B in column-major order and is taken while in_stall
// is low; in_stall stays high while the product is being issued. After n*n
// requests the product is formed column by column: one lane per row does one
// multiply-accumulate per cycle while a column is being issued, and the lanes'
// results are handed out one per cycle, unless out_stall holds them, in
// column-major order with the final element marked by last. At most two
// columns may sit between issue and the output, so for n of 3 or 4 the third
// column waits for the first one to drain, and longer while out_stall holds.
// A column's sums pass through the lane result registers and the merge's bank
// and output registers, and the last elements of a product can leave while the
// next pair is loading. Elements are signed Q16.16, sums are exact, truncated
// toward minus infinity and clipped with saturated set.
module small_square_matrix_multiply
    import ssmm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [DIM_W-1:0] cfg_data,
    input  logic             in_valid,
    output logic             in_stall,
    input  elem_t            a_value,
    input  elem_t            b_value,
    output logic             out_valid,
    input  logic             out_stall,
    output elem_t            c_value,
    output logic             saturated,
    output logic             last
);

    typedef enum logic {
        ST_LOAD,
        ST_CALC
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    logic [DIM_W-1:0] dim_reg;
    logic [DIM_W-1:0] dim_next;
    logic [CNT_W-1:0] load_count_reg;
    logic [CNT_W-1:0] load_count_next;
    logic [N_W-1:0]   n_reg;
    logic [N_W-1:0]   n_next;
    logic [IDX_W-1:0] j_reg;
    logic [IDX_W-1:0] j_next;
    logic [IDX_W-1:0] k_reg;
    logic [IDX_W-1:0] k_next;
    logic [1:0]       cols_busy_reg;
    logic [1:0]       cols_busy_next;
    ctrl_t            s1_reg;
    ctrl_t            s2_reg;
    ctrl_t            s3_reg;

    logic [N_W-1:0]    n_cfg;
    logic [CNT_W-1:0]  total;
    logic [CNT_W-1:0]  count_inc;
    logic              accept;
    logic              issue;
    logic              col_start;
    logic              k_last;
    logic              j_last;
    logic              col_done;
    ctrl_t             s0;
    logic [ADDR_W-1:0] row_base;
    logic [ADDR_W-1:0] b_raddr;
    logic [ADDR_W-1:0] a_raddr [MAX_DIM];
    logic [ELEM_WIDTH-1:0] b_rdata;
    lane_res_t         lane_res [MAX_DIM];

    function automatic logic [N_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
        logic [N_W-1:0] n;
        begin
            n = N_W'(d);
            if (d < DIM_W'(2))
            begin
                n = N_W'(2);
            end
            else if (N_W'(d) > N_W'(MAX_DIM))
            begin
                n = N_W'(MAX_DIM);
            end
            return n;
        end
    endfunction

    always_comb
    begin
        n_cfg     = clamp_dim(dim_reg);
        total     = CNT_W'(CNT_W'(n_cfg) * CNT_W'(n_cfg));
        count_inc = load_count_reg + CNT_W'(1);
        accept    = in_valid && (state_reg == ST_LOAD);
        k_last    = (k_reg == IDX_W'(n_reg - N_W'(1)));
        j_last    = (j_reg == IDX_W'(n_reg - N_W'(1)));
        issue     = (state_reg == ST_CALC) && ((k_reg != '0) || (cols_busy_reg < 2'd2));
        col_start = issue && (k_reg == '0);
        row_base  = ADDR_W'(ADDR_W'(k_reg) * ADDR_W'(n_reg));
        b_raddr   = ADDR_W'(ADDR_W'(j_reg) * ADDR_W'(n_reg)) + ADDR_W'(k_reg);

        s0.valid    = issue;
        s0.first    = (k_reg == '0);
        s0.last     = k_last;
        s0.col_last = j_last;
        s0.n        = n_reg;
    end

    always_comb
    begin
        state_next      = state_reg;
        dim_next        = cfg_we ? cfg_data : dim_reg;
        load_count_next = load_count_reg;
        n_next          = n_reg;
        j_next          = j_reg;
        k_next          = k_reg;

        case (state_reg)
            ST_LOAD:
            begin
                if (accept)
                begin
                    if (count_inc >= total)
                    begin
                        state_next      = ST_CALC;
                        load_count_next = '0;
                        n_next          = n_cfg;
                        j_next          = '0;
                        k_next          = '0;
                    end
                    else
                    begin
                        load_count_next = count_inc;
                    end
                end
            end
            ST_CALC:
            begin
                if (issue)
                begin
                    if (k_last)
                    begin
                        k_next = '0;
                        j_next = j_reg + IDX_W'(1);
                        if (j_last)
                        begin
                            state_next = ST_LOAD;
                        end
                    end
                    else
                    begin
                        k_next = k_reg + IDX_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase

        // columns held anywhere from issue until their last element leaves the output bank
        case ({col_start, col_done})
            2'b10:   cols_busy_next = cols_busy_reg + 2'd1;
            2'b01:   cols_busy_next = cols_busy_reg - 2'd1;
            default: cols_busy_next = cols_busy_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_LOAD;
            dim_reg        <= DIM_W'(4);
            load_count_reg <= '0;
            n_reg          <= N_W'(MAX_DIM);
            j_reg          <= '0;
            k_reg          <= '0;
            cols_busy_reg  <= '0;
            s1_reg         <= '0;
            s2_reg         <= '0;
            s3_reg         <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            dim_reg        <= dim_next;
            load_count_reg <= load_count_next;
            n_reg          <= n_next;
            j_reg          <= j_next;
            k_reg          <= k_next;
            cols_busy_reg  <= cols_busy_next;
            s1_reg         <= s0;
            s2_reg         <= s1_reg;
            s3_reg         <= s2_reg;
        end
    end

    assign in_stall = (state_reg != ST_LOAD);

    ssmm_ram #(
        .DEPTH (DEPTH),
        .WIDTH (ELEM_WIDTH)
    ) u_b_ram (
        .clk   (clk),
        .we    (accept),
        .waddr (load_count_reg[ADDR_W-1:0]),
        .wdata (b_value),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

    for (genvar gi = 0; gi < MAX_DIM; gi++)
    begin : g_lane
        assign a_raddr[gi] = row_base + ADDR_W'(gi);

        ssmm_lane u_lane (
            .clk     (clk),
            .a_we    (accept),
            .a_waddr (load_count_reg[ADDR_W-1:0]),
            .a_wdata (a_value),
            .a_raddr (a_raddr[gi]),
            .b_rdata ($signed(b_rdata)),
            .acc_en  (s2_reg.valid),
            .acc_clr (s2_reg.first),
            .hold    (s3_reg.valid && s3_reg.last),
            .res     (lane_res[gi])
        );
    end

    ssmm_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .hold      (s3_reg.valid && s3_reg.last),
        .hold_ctrl (s3_reg),
        .lane_res  (lane_res),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .c_value   (c_value),
        .saturated (saturated),
        .last      (last),
        .col_done  (col_done)
    );

    `SSMM_ASSERT_NEVER(a_credit_bound, cols_busy_reg > 2'd2)
    `SSMM_ASSERT_NEVER(a_count_range, load_count_reg >= CNT_W'(DEPTH))
    `SSMM_ASSERT(a_calc_exit, issue && k_last && j_last |=> state_reg == ST_LOAD)

endmodule
